### sv/akg_pkg.sv
// Shared codes and types for the length-prefix to start-code keyframe gate.
// Used by the front end, the back end and the top level; no dependencies.
`default_nettype none

package akg_pkg;

  typedef logic [1:0] func_t;
  typedef logic [2:0] cmd_kind_t;

  // Input item functions
  localparam func_t FUNC_PKT    = 2'd0;
  localparam func_t FUNC_SPS    = 2'd1;
  localparam func_t FUNC_PPS    = 2'd2;
  localparam func_t FUNC_RESYNC = 2'd3;

  // Commands passed from the front end to the back end
  localparam int KIND_W = 3;
  localparam cmd_kind_t CMD_LOAD_SPS = 3'd0;
  localparam cmd_kind_t CMD_LOAD_PPS = 3'd1;
  localparam cmd_kind_t CMD_UNIT     = 3'd2;  // start code, then header byte
  localparam cmd_kind_t CMD_KEY      = 3'd3;  // SPS, PPS, start code, header byte
  localparam cmd_kind_t CMD_BYTE     = 3'd4;  // one body byte

  localparam logic [7:0] NAL_TYPE_MASK = 8'h1F;
  localparam logic [7:0] NAL_IDR       = 8'h05;
  localparam logic [7:0] START_BYTE    = 8'h01;
  localparam logic [2:0] PREFIX_BYTES  = 3'd4;

endpackage

`default_nettype wire

### sv/akg_front.sv
// Front end: accepts input beats, parses length prefixes and unit headers,
// tracks parameter set lengths and issues commands. Depends on akg_pkg.
`default_nettype none

module akg_front #(
  parameter int PS_BYTES = 28,
  parameter int CMD_W    = 3 + 8 + 2 * $clog2(PS_BYTES + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,   // in_byte
  input  wire logic [2:0]        in_tuser,   // func[1:0], first[2]
  input  wire logic              in_tlast,   // last
  input  wire logic              cfg_we,
  input  wire logic              cfg_wdata,  // h264_mode
  input  wire logic              q_full,
  output logic                   q_push,
  output logic [CMD_W-1:0]       q_data
);
  import akg_pkg::*;

  localparam int LEN_W = $clog2(PS_BYTES + 1);
  localparam logic [LEN_W-1:0] PS_LIMIT = LEN_W'(PS_BYTES);

  logic             mode_r, mode_nxt;
  logic             kf_r, kf_nxt;
  logic [LEN_W-1:0] sps_len_r, sps_len_nxt;
  logic [LEN_W-1:0] pps_len_r, pps_len_nxt;
  logic [2:0]       pc_r, pc_nxt;
  logic [31:0]      len_r, len_nxt;
  logic             pass_r, pass_nxt;

  func_t            func;
  logic             first_b;
  logic             acc;
  logic [31:0]      shifted;
  logic             rem_end;
  logic             is_idr;
  logic [LEN_W-1:0] ld_addr;
  logic             ld_ok;
  cmd_kind_t        cmd_kind;
  logic [2*LEN_W-1:0] cmd_arg;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;
  assign func      = in_tuser[1:0];
  assign first_b   = in_tuser[2];
  assign shifted   = {len_r[23:0], in_tdata};
  assign rem_end   = (len_r <= 32'd1);
  assign is_idr    = ((in_tdata & NAL_TYPE_MASK) == NAL_IDR);
  assign q_data    = {cmd_arg, in_tdata, cmd_kind};

  always_comb begin
    mode_nxt    = cfg_we ? cfg_wdata : mode_r;
    kf_nxt      = kf_r;
    sps_len_nxt = sps_len_r;
    pps_len_nxt = pps_len_r;
    pc_nxt      = pc_r;
    len_nxt     = len_r;
    pass_nxt    = pass_r;
    q_push      = 1'b0;
    cmd_kind    = CMD_BYTE;
    cmd_arg     = '0;
    ld_addr     = '0;
    ld_ok       = 1'b0;
    if (acc) begin
      unique case (func)
        FUNC_SPS: begin
          ld_addr = first_b ? '0 : sps_len_r;
          ld_ok   = first_b || (sps_len_r < PS_LIMIT);
          if (ld_ok) begin
            q_push      = 1'b1;
            cmd_kind    = CMD_LOAD_SPS;
            cmd_arg     = {{LEN_W{1'b0}}, ld_addr};
            sps_len_nxt = ld_addr + LEN_W'(1);
          end
        end
        FUNC_PPS: begin
          ld_addr = first_b ? '0 : pps_len_r;
          ld_ok   = first_b || (pps_len_r < PS_LIMIT);
          if (ld_ok) begin
            q_push      = 1'b1;
            cmd_kind    = CMD_LOAD_PPS;
            cmd_arg     = {{LEN_W{1'b0}}, ld_addr};
            pps_len_nxt = ld_addr + LEN_W'(1);
          end
        end
        FUNC_RESYNC: begin
          kf_nxt   = 1'b0;
          pc_nxt   = '0;
          len_nxt  = '0;
          pass_nxt = 1'b0;
        end
        FUNC_PKT: begin
          if (!mode_r) begin
            pc_nxt   = '0;
            len_nxt  = '0;
            pass_nxt = 1'b0;
          end else begin
            if (pc_r < PREFIX_BYTES) begin
              len_nxt = shifted;
              pc_nxt  = pc_r + 3'd1;
              // zero-length unit: skip straight to the next prefix
              if (pc_r == PREFIX_BYTES - 3'd1 && shifted == 32'd0) begin
                pc_nxt = '0;
              end
            end else begin
              if (pc_r == PREFIX_BYTES) begin
                pass_nxt = 1'b0;
                pc_nxt   = pc_r + 3'd1;
                if (is_idr && !kf_r) begin
                  if (sps_len_r != '0 && pps_len_r != '0) begin
                    kf_nxt   = 1'b1;
                    pass_nxt = 1'b1;
                    q_push   = 1'b1;
                    cmd_kind = CMD_KEY;
                    cmd_arg  = {pps_len_r, sps_len_r};
                  end
                end else if (kf_r) begin
                  pass_nxt = 1'b1;
                  q_push   = 1'b1;
                  cmd_kind = CMD_UNIT;
                end
              end else if (pass_r) begin
                q_push   = 1'b1;
                cmd_kind = CMD_BYTE;
              end
              len_nxt = len_r - 32'd1;
              if (rem_end) begin
                pc_nxt   = '0;
                len_nxt  = '0;
                pass_nxt = 1'b0;
              end
            end
            if (in_tlast) begin
              pc_nxt   = '0;
              len_nxt  = '0;
              pass_nxt = 1'b0;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b1;
      kf_r      <= 1'b0;
      sps_len_r <= '0;
      pps_len_r <= '0;
      pc_r      <= '0;
      len_r     <= '0;
      pass_r    <= 1'b0;
    end else begin
      mode_r    <= mode_nxt;
      kf_r      <= kf_nxt;
      sps_len_r <= sps_len_nxt;
      pps_len_r <= pps_len_nxt;
      pc_r      <= pc_nxt;
      len_r     <= len_nxt;
      pass_r    <= pass_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/akg_fifo.sv
// Small command queue between front end and back end, register based.
// Depth must be a power of two. No package dependency.
`default_nettype none

module akg_fifo #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/akg_back.sv
// Back end: holds the parameter set stores and plays commands out as
// output beats through a registered output stage. Depends on akg_pkg.
`default_nettype none

module akg_back #(
  parameter int PS_BYTES = 28,
  parameter int CMD_W    = 3 + 8 + 2 * $clog2(PS_BYTES + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_empty,
  output logic                  q_pop,
  input  wire logic [CMD_W-1:0] q_data,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [7:0]            out_tdata,  // out_byte
  output logic                  out_tuser,  // nal_first
  output logic                  out_tlast   // run_last
);
  import akg_pkg::*;

  localparam int LEN_W = $clog2(PS_BYTES + 1);
  localparam int IDX_W = $clog2(PS_BYTES);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_SPS  = 3'd1;
  localparam logic [2:0] PH_PPS  = 3'd2;
  localparam logic [2:0] PH_SC   = 3'd3;
  localparam logic [2:0] PH_BYTE = 3'd4;

  logic [7:0]       sps_mem_r [PS_BYTES];
  logic [7:0]       pps_mem_r [PS_BYTES];

  logic [2:0]       phase_r, phase_nxt;
  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic [7:0]       hdr_r, hdr_nxt;
  logic [LEN_W-1:0] sps_len_r, sps_len_nxt;
  logic [LEN_W-1:0] pps_len_r, pps_len_nxt;

  logic             ov_r, ov_nxt;
  logic [7:0]       ob_r, ob_nxt;
  logic             of_r, of_nxt;
  logic             ol_r, ol_nxt;

  cmd_kind_t        c_kind;
  logic [7:0]       c_data;
  logic [2*LEN_W-1:0] c_arg;
  logic             advance;
  logic             emit;
  logic [7:0]       e_byte;
  logic             e_first;
  logic             e_last;
  logic             we_sps, we_pps;

  assign c_kind  = q_data[KIND_W-1:0];
  assign c_data  = q_data[KIND_W+7:KIND_W];
  assign c_arg   = q_data[CMD_W-1:KIND_W+8];
  assign advance = !ov_r || out_tready;

  assign out_tvalid = ov_r;
  assign out_tdata  = ob_r;
  assign out_tuser  = of_r;
  assign out_tlast  = ol_r;

  always_comb begin
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    hdr_nxt     = hdr_r;
    sps_len_nxt = sps_len_r;
    pps_len_nxt = pps_len_r;
    q_pop       = 1'b0;
    emit        = 1'b0;
    e_byte      = hdr_r;
    e_first     = 1'b0;
    e_last      = 1'b0;
    we_sps      = 1'b0;
    we_pps      = 1'b0;
    if (advance) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (!q_empty) begin
            q_pop = 1'b1;
            unique case (c_kind)
              CMD_LOAD_SPS: we_sps = 1'b1;
              CMD_LOAD_PPS: we_pps = 1'b1;
              CMD_KEY: begin
                phase_nxt   = PH_SPS;
                idx_nxt     = '0;
                hdr_nxt     = c_data;
                sps_len_nxt = c_arg[LEN_W-1:0];
                pps_len_nxt = c_arg[2*LEN_W-1:LEN_W];
              end
              CMD_UNIT: begin
                phase_nxt = PH_SC;
                idx_nxt   = '0;
                hdr_nxt   = c_data;
              end
              CMD_BYTE: begin
                emit   = 1'b1;
                e_byte = c_data;
                e_last = 1'b1;
              end
              default: ;
            endcase
          end
        end
        PH_SPS: begin
          emit    = 1'b1;
          e_byte  = sps_mem_r[idx_r[IDX_W-1:0]];
          e_first = (idx_r == '0);
          if (idx_r == sps_len_r - LEN_W'(1)) begin
            phase_nxt = PH_PPS;
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_r + LEN_W'(1);
          end
        end
        PH_PPS: begin
          emit    = 1'b1;
          e_byte  = pps_mem_r[idx_r[IDX_W-1:0]];
          e_first = (idx_r == '0);
          if (idx_r == pps_len_r - LEN_W'(1)) begin
            phase_nxt = PH_SC;
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_r + LEN_W'(1);
          end
        end
        PH_SC: begin
          emit    = 1'b1;
          e_first = (idx_r == '0);
          e_byte  = (idx_r == LEN_W'(3)) ? START_BYTE : 8'h00;
          if (idx_r == LEN_W'(3)) begin
            phase_nxt = PH_BYTE;
          end
          idx_nxt = idx_r + LEN_W'(1);
        end
        PH_BYTE: begin
          emit      = 1'b1;
          e_byte    = hdr_r;
          e_last    = 1'b1;
          phase_nxt = PH_IDLE;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // Output stage: load a fresh beat whenever the held one is gone
  always_comb begin
    ov_nxt = ov_r;
    ob_nxt = ob_r;
    of_nxt = of_r;
    ol_nxt = ol_r;
    if (advance) begin
      ov_nxt = emit;
      ob_nxt = e_byte;
      of_nxt = e_first;
      ol_nxt = e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (we_sps) begin
      sps_mem_r[c_arg[IDX_W-1:0]] <= c_data;
    end
    if (we_pps) begin
      pps_mem_r[c_arg[IDX_W-1:0]] <= c_data;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    hdr_r     <= hdr_nxt;
    sps_len_r <= sps_len_nxt;
    pps_len_r <= pps_len_nxt;
    ob_r      <= ob_nxt;
    of_r      <= of_nxt;
    ol_r      <= ol_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      ov_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/avcc_to_annexb_keyframe_gate_core.sv
// Top level of the length-prefix to start-code converter with keyframe gate.
// Instantiates akg_front, akg_fifo and akg_back; depends on akg_pkg.
//
// Converts H.264 packets, one byte per beat, from 4-byte length-prefixed
// units to 00 00 00 01 start-code units; nothing passes until the first IDR
// header arrives with both parameter sets loaded, at which point the stored
// SPS and PPS are sent ahead of it. The front end takes one input beat per
// cycle, bounded by its single-cycle 32-bit length count-down, whenever the
// command queue (QUEUE_DEPTH entries) has room. The back end sends at most one
// output beat per cycle while out_tready allows: a body byte is staged as its
// command is taken; a unit header takes the command, then sends the start code
// and header; a keyframe header sends the stored SPS and PPS first, while the
// front end runs on until the queue fills. Each load writes its store as the
// back end takes it. Loads and resyncs give no output; stores need no reset.
`default_nettype none

module avcc_to_annexb_keyframe_gate_core #(
  parameter int PS_BYTES    = 28,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // in_byte
  input  wire logic [2:0] in_tuser,   // func[1:0], first[2]
  input  wire logic       in_tlast,   // last
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // out_byte
  output logic            out_tuser,  // nal_first
  output logic            out_tlast,  // run_last
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata   // h264_mode
);
  import akg_pkg::*;

  localparam int LEN_W = $clog2(PS_BYTES + 1);
  localparam int CMD_W = KIND_W + 8 + 2 * LEN_W;

  logic             q_full, q_empty, q_push, q_pop;
  logic [CMD_W-1:0] q_wdata, q_rdata;

  akg_front #(
    .PS_BYTES (PS_BYTES),
    .CMD_W    (CMD_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  akg_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  akg_back #(
    .PS_BYTES (PS_BYTES),
    .CMD_W    (CMD_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_data     (q_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

### sv/akg_checker.sv
// Port-level checks for the keyframe gate, bound to the top level.
// Sees only the top-level ports; no package dependency.
`default_nettype none

module akg_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tuser,
  input wire logic       out_tlast
);

  // Held beat must not change while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A run always ends on a unit byte, never on the opening byte of a unit
  a_last_not_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> !out_tuser)
    else $error("run ends on an opening byte");

  // Within a run the beats follow without gaps
  a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside an output run");

endmodule

bind avcc_to_annexb_keyframe_gate_core akg_checker u_akg_checker (.*);

`default_nettype wire
